>>> hdl/rle_pkg.sv
package rle_pkg;

  // Longest run a count may ask for
  localparam int unsigned MAX_RUN = 10;
  // Width of the two length counters
  localparam int unsigned LENGTH_BITS = 32;

  // Run count saturates one above the longest legal run
  localparam int unsigned CNT_W = $clog2(MAX_RUN + 2);
  // Width of the shared adder's increment operand
  localparam int unsigned ADD_W = 2;

  // Decimal base of the count digits
  localparam int unsigned DEC_BASE = 10;
  // Largest count that still fits in one digit
  localparam int unsigned ONE_DIGIT_MAX = 9;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DASH  = 8'h2d;
  localparam logic [7:0] CHAR_DEL   = 8'h7f;

  // Result status codes
  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_COUNT = 2'd1,
    PH_CHAR  = 2'd2,
    PH_LIT   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_RUN  = 2'd1,
    ACT_DONE = 2'd2,
    ACT_ERR  = 2'd3
  } action_e;

  // Decision of the parser for one input word
  typedef struct packed {
    action_e            act;
    phase_e             phase;
    logic [CNT_W-1:0]   count;
    logic [ADD_W-1:0]   pack_add;
  } rle_step_t;

endpackage

>>> hdl/rle_sat_add.sv
module rle_sat_add import rle_pkg::*; (
  input  logic [LENGTH_BITS-1:0] a_i,
  input  logic [ADD_W-1:0]       b_i,
  output logic [LENGTH_BITS-1:0] sum_o
);

  logic [LENGTH_BITS:0] wide;

  // Add a small step and clamp at the all-ones value
  always_comb begin
    wide = {1'b0, a_i} + (LENGTH_BITS + 1)'(b_i);
    if (wide[LENGTH_BITS]) begin
      sum_o = '1;
    end else begin
      sum_o = wide[LENGTH_BITS-1:0];
    end
  end

endmodule

>>> hdl/rle_parse.sv
module rle_parse import rle_pkg::*; (
  input  phase_e           phase_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [7:0]       byte_i,
  output rle_step_t        step_o
);

  localparam int unsigned VW = CNT_W + 8;

  logic          is_ctrl;
  logic          is_space;
  logic          is_digit;
  logic          is_dash;
  logic [VW-1:0] base;
  logic [VW-1:0] acc;
  logic [CNT_W-1:0] acc_sat;
  logic          count_bad;
  logic [ADD_W-1:0] close_add;

  // Classify the incoming word
  always_comb begin
    is_ctrl  = (byte_i < CHAR_SPACE) || (byte_i == CHAR_DEL);
    is_space = (byte_i == CHAR_SPACE);
    is_digit = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
    is_dash  = (byte_i == CHAR_DASH);
  end

  // Accumulate one decimal digit, saturating one above the longest run
  always_comb begin
    base = (phase_i == PH_START) ? '0 : VW'(count_i);
    acc  = base * VW'(DEC_BASE) + VW'(byte_i - CHAR_ZERO);
    if (acc > VW'(MAX_RUN)) begin
      acc_sat = CNT_W'(MAX_RUN + 1);
    end else begin
      acc_sat = acc[CNT_W-1:0];
    end
    count_bad = (count_i == '0) || (VW'(count_i) > VW'(MAX_RUN));
    close_add = (VW'(count_i) > VW'(ONE_DIGIT_MAX)) ? ADD_W'(2) : ADD_W'(1);
  end

  // Decide the next phase and what the word causes
  always_comb begin
    step_o.act      = ACT_NONE;
    step_o.phase    = phase_i;
    step_o.count    = count_i;
    step_o.pack_add = '0;
    unique case (phase_i)
      PH_START: begin
        if (is_ctrl) begin
          step_o.act = ACT_DONE;
        end else if (is_space) begin
          step_o.act = ACT_NONE;
        end else if (!is_digit) begin
          step_o.act = ACT_ERR;
        end else begin
          step_o.count = acc_sat;
          step_o.phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (is_ctrl) begin
          step_o.act = ACT_ERR;
        end else if (is_digit) begin
          step_o.count = acc_sat;
        end else if (count_bad) begin
          step_o.act = ACT_ERR;
        end else if (is_space) begin
          step_o.pack_add = close_add;
          step_o.phase    = PH_CHAR;
        end else if (is_dash) begin
          step_o.pack_add = close_add + ADD_W'(1);
          step_o.phase    = PH_LIT;
        end else begin
          step_o.act      = ACT_RUN;
          step_o.pack_add = close_add + ADD_W'(1);
          step_o.phase    = PH_START;
          step_o.count    = '0;
        end
      end
      PH_CHAR: begin
        if (is_ctrl) begin
          step_o.act = ACT_ERR;
        end else if (is_space) begin
          step_o.act = ACT_NONE;
        end else if (is_dash) begin
          step_o.pack_add = ADD_W'(1);
          step_o.phase    = PH_LIT;
        end else begin
          step_o.act      = ACT_RUN;
          step_o.pack_add = ADD_W'(1);
          step_o.phase    = PH_START;
          step_o.count    = '0;
        end
      end
      PH_LIT: begin
        if (is_ctrl) begin
          step_o.act = ACT_ERR;
        end else if (is_space) begin
          step_o.act = ACT_NONE;
        end else begin
          step_o.act      = ACT_RUN;
          step_o.pack_add = ADD_W'(1);
          step_o.phase    = PH_START;
          step_o.count    = '0;
        end
      end
      default: begin
        step_o.act = ACT_ERR;
      end
    endcase
  end

endmodule

>>> hdl/rle_text_decoder_unit.sv
// Run-length text decoder. Compressed text enters one byte per accepted word;
// each pair is a decimal count of 1 to 10 followed by a character, and a '-'
// in the character position makes the next byte the literal. Spaces between
// symbols are skipped. A byte that completes a pair of count n is parsed, then
// its n copies are emitted, one per cycle while the output is not stalled,
// because a single saturating adder updates the compressed length on the parse
// cycle and the expanded length on every copy. Input is stalled meanwhile.
// Each result carries both running lengths. A control byte at a pair boundary
// yields a done result; a control byte inside a pair, a count of zero or
// above ten, or a non-digit where a count is due yields an error result.
// Either one clears the lengths and starts a new stream.
module rle_text_decoder_unit import rle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic [1:0]  status_o,
  output logic [31:0] compressed_length_o,
  output logic [31:0] expanded_length_o
);

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } state_e;

  function automatic logic [31:0] len_out(input logic [LENGTH_BITS-1:0] v);
    logic [63:0] t;
    t = 64'(v);
    return t[31:0];
  endfunction

  state_e                 state_q, state_d;
  phase_e                 phase_q, phase_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       remain_q, remain_d;
  logic [7:0]             char_q, char_d;
  logic [LENGTH_BITS-1:0] packed_q, packed_d;
  logic [LENGTH_BITS-1:0] unpacked_q, unpacked_d;

  logic                   out_valid_q, out_valid_d;
  logic [7:0]             out_byte_q, out_byte_d;
  logic                   run_last_q, run_last_d;
  logic [1:0]             status_q, status_d;
  logic [31:0]            comp_len_q, comp_len_d;
  logic [31:0]            exp_len_q, exp_len_d;

  rle_step_t              step;
  logic                   out_free;
  logic                   in_take;
  logic [LENGTH_BITS-1:0] add_a;
  logic [ADD_W-1:0]       add_b;
  logic [LENGTH_BITS-1:0] add_sum;

  rle_parse u_parse (
    .phase_i (phase_q),
    .count_i (count_q),
    .byte_i  (in_byte_i),
    .step_o  (step)
  );

  // Share one saturating adder between both length counters
  assign add_a = (state_q == S_RUN) ? unpacked_q : packed_q;
  assign add_b = (state_q == S_RUN) ? ADD_W'(1) : step.pack_add;

  rle_sat_add u_sat_add (
    .a_i   (add_a),
    .b_i   (add_b),
    .sum_o (add_sum)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_take    = in_valid_i && !in_stall_o;

  // Sequence parsing and run emission
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    count_d     = count_q;
    remain_d    = remain_q;
    char_d      = char_q;
    packed_d    = packed_q;
    unpacked_d  = unpacked_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    run_last_d  = run_last_q;
    status_d    = status_q;
    comp_len_d  = comp_len_q;
    exp_len_d   = exp_len_q;

    // Drop the output word once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          unique case (step.act)
            ACT_NONE: begin
              phase_d  = step.phase;
              count_d  = step.count;
              packed_d = add_sum;
            end
            ACT_RUN: begin
              packed_d = add_sum;
              char_d   = in_byte_i;
              remain_d = count_q;
              phase_d  = PH_START;
              count_d  = '0;
              state_d  = S_RUN;
            end
            ACT_DONE, ACT_ERR: begin
              out_valid_d = 1'b1;
              out_byte_d  = '0;
              run_last_d  = 1'b0;
              status_d    = (step.act == ACT_DONE) ? ST_DONE : ST_ERR;
              comp_len_d  = len_out(packed_q);
              exp_len_d   = len_out(unpacked_q);
              phase_d     = PH_START;
              count_d     = '0;
              packed_d    = '0;
              unpacked_d  = '0;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RUN: begin
        // Emit one copy per free output slot
        if (out_free) begin
          unpacked_d  = add_sum;
          out_valid_d = 1'b1;
          out_byte_d  = char_q;
          run_last_d  = (remain_q == CNT_W'(1));
          status_d    = ST_DATA;
          comp_len_d  = len_out(packed_q);
          exp_len_d   = len_out(add_sum);
          remain_d    = remain_q - CNT_W'(1);
          if (remain_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_START;
      count_q     <= '0;
      remain_q    <= '0;
      packed_q    <= '0;
      unpacked_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      packed_q    <= packed_d;
      unpacked_q  <= unpacked_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Advance payload registers
  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    out_byte_q <= out_byte_d;
    run_last_q <= run_last_d;
    status_q   <= status_d;
    comp_len_q <= comp_len_d;
    exp_len_q  <= exp_len_d;
  end

  assign out_valid_o         = out_valid_q;
  assign out_byte_o          = out_byte_q;
  assign run_last_o          = run_last_q;
  assign status_o            = status_q;
  assign compressed_length_o = comp_len_q;
  assign expanded_length_o   = exp_len_q;

endmodule
